@@ rtl/srec_pkg.sv @@
// Shared types, constants and helpers of the S-record parser.
// No dependencies; imported by every other file but srec_if and srec_checker.
package srec_pkg;

    localparam int          MAX_DATA_BYTES_DEF = 16;
    localparam int          QUEUE_DEPTH        = 4;
    localparam logic [7:0]  CHAR_S             = 8'h53;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TYPE,
        PH_COUNT,
        PH_BODY
    } phase_t;

    typedef enum logic [2:0] {
        TK_START,
        TK_TYPE,
        TK_COUNT,
        TK_DATA,
        TK_CHECK
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] value;
    } token_t;

    // Hex digit value; anything that is not a hex digit gives zero.
    function automatic logic [3:0] nib_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'h0;
        if (c inside {[8'h30:8'h39]})
        begin
            n = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            n = c[3:0] + 4'd9;
        end
        return n;
    endfunction

endpackage

@@ rtl/srec_if.sv @@
// Channel interfaces of the S-record parser: characters in, records out.
// Depends on nothing; valid/ready handshake, one beat per accepted item.
interface srec_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface srec_rec_if;
    logic        valid;
    logic        ready;
    logic [3:0]  record_type;
    logic [15:0] load_address;
    logic [7:0]  byte_count;
    logic        record_valid;
    logic [31:0] data_word0;
    logic [31:0] data_word1;
    logic [31:0] data_word2;
    logic [31:0] data_word3;

    modport source (output valid, output record_type, output load_address,
                    output byte_count, output record_valid, output data_word0,
                    output data_word1, output data_word2, output data_word3,
                    input ready);
    modport sink   (input valid, input record_type, input load_address,
                    input byte_count, input record_valid, input data_word0,
                    input data_word1, input data_word2, input data_word3,
                    output ready);
endinterface

@@ rtl/srec_front.sv @@
// Front end: tracks the record framing and pairs hex nibbles into tokens.
// Depends on srec_pkg.
module srec_front
    import srec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  logic [7:0] char_in,
    output logic       push,
    output token_t     token,
    input  logic       queue_full
);

    phase_t     phase_reg, phase_next;
    logic       toggle_reg, toggle_next;
    logic [3:0] high_reg, high_next;
    logic [7:0] left_reg, left_next;
    logic       fire;
    logic [3:0] nib;
    logic [7:0] pair;

    assign char_ready = !queue_full;
    assign fire       = char_valid && !queue_full;
    assign nib        = nib_of(char_in);
    assign pair       = {high_reg, nib};

    always_comb
    begin
        phase_next  = phase_reg;
        toggle_next = toggle_reg;
        high_next   = high_reg;
        left_next   = left_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (fire && char_in == CHAR_S)
                begin
                    phase_next  = PH_TYPE;
                    toggle_next = 1'b0;
                end
            end
            PH_TYPE:
            begin
                if (fire)
                begin
                    phase_next  = PH_COUNT;
                    toggle_next = 1'b0;
                end
            end
            PH_COUNT:
            begin
                if (fire)
                begin
                    if (!toggle_reg)
                    begin
                        high_next   = nib;
                        toggle_next = 1'b1;
                    end
                    else
                    begin
                        toggle_next = 1'b0;
                        left_next   = pair;
                        phase_next  = (pair == 8'd0) ? PH_IDLE : PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                if (fire)
                begin
                    if (!toggle_reg)
                    begin
                        high_next   = nib;
                        toggle_next = 1'b1;
                    end
                    else
                    begin
                        toggle_next = 1'b0;
                        if (left_reg <= 8'd1)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            left_next = left_reg - 8'd1;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        push        = 1'b0;
        token.kind  = TK_START;
        token.value = pair;
        case (phase_reg)
            PH_IDLE:
            begin
                push = fire && char_in == CHAR_S;
            end
            PH_TYPE:
            begin
                push        = fire;
                token.kind  = TK_TYPE;
                token.value = {4'h0, nib};
            end
            PH_COUNT:
            begin
                push       = fire && toggle_reg;
                token.kind = TK_COUNT;
            end
            PH_BODY:
            begin
                push       = fire && toggle_reg;
                token.kind = (left_reg <= 8'd1) ? TK_CHECK : TK_DATA;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            toggle_reg <= 1'b0;
            high_reg   <= 4'h0;
            left_reg   <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            toggle_reg <= toggle_next;
            high_reg   <= high_next;
            left_reg   <= left_next;
        end
    end

endmodule

@@ rtl/srec_token_queue.sv @@
// Short token queue between front and back end.
// Depends on srec_pkg (token_t, QUEUE_DEPTH).
module srec_token_queue
    import srec_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t wr_token,
    output logic   full,
    input  logic   pop,
    output token_t rd_token,
    output logic   empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    token_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   fill_reg, fill_next;

    assign full     = fill_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign empty    = fill_reg == '0;
    assign rd_token = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (PTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule

@@ rtl/srec_back.sv @@
// Back end: executes tokens (checksum, address, data store) and holds the
// finished record in an output register. Depends on srec_pkg.
module srec_back
    import srec_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  token_t      head,
    input  logic        queue_empty,
    output logic        pop,
    output logic        rec_valid,
    input  logic        rec_ready,
    output logic [3:0]  record_type,
    output logic [15:0] load_address,
    output logic [7:0]  byte_count,
    output logic        record_valid,
    output logic [31:0] data_word0,
    output logic [31:0] data_word1,
    output logic [31:0] data_word2,
    output logic [31:0] data_word3
);

    localparam int         IDX_W = $clog2(MAX_DATA_BYTES);
    localparam logic [7:0] MAX_B = 8'(MAX_DATA_BYTES);

    logic [3:0]  type_reg, type_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  index_reg, index_next;
    logic [7:0]  store_reg [MAX_DATA_BYTES];
    logic [7:0]  store_next [MAX_DATA_BYTES];

    logic        out_valid_reg, out_valid_next;
    logic [3:0]  out_type_reg;
    logic [15:0] out_addr_reg;
    logic [7:0]  out_count_reg;
    logic        out_ok_reg;
    logic [3:0][31:0] words;
    logic [3:0][31:0] out_words_reg;

    logic        emits;
    logic        slot_free;
    logic        ok;
    logic [7:0]  data_pos;

    // Bytes past the store read as zero.
    for (genvar k = 0; k < 4; k++)
    begin : g_word
        for (genvar b = 0; b < 4; b++)
        begin : g_byte
            if (4 * k + b < MAX_DATA_BYTES)
            begin : g_held
                assign words[k][31-8*b -: 8] = store_reg[4*k+b];
            end
            else
            begin : g_zero
                assign words[k][31-8*b -: 8] = 8'h00;
            end
        end
    end

    assign emits     = head.kind == TK_CHECK || (head.kind == TK_COUNT && head.value == 8'd0);
    assign slot_free = !out_valid_reg || rec_ready;
    assign pop       = !queue_empty && (slot_free || !emits);
    assign ok        = head.kind == TK_CHECK && ~sum_reg == head.value;
    assign data_pos  = index_reg - 8'd2;

    always_comb
    begin
        type_next  = type_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        addr_next  = addr_reg;
        index_next = index_reg;
        store_next = store_reg;
        if (pop)
        begin
            case (head.kind)
                TK_START:
                begin
                    type_next  = 4'h0;
                    count_next = 8'd0;
                    sum_next   = 8'd0;
                    addr_next  = 16'd0;
                    index_next = 8'd0;
                    for (int i = 0; i < MAX_DATA_BYTES; i++)
                    begin
                        store_next[i] = 8'h00;
                    end
                end
                TK_TYPE:
                begin
                    type_next = head.value[3:0];
                end
                TK_COUNT:
                begin
                    count_next = head.value;
                    sum_next   = head.value;
                    index_next = 8'd0;
                end
                TK_DATA:
                begin
                    sum_next = sum_reg + head.value;
                    if (index_reg == 8'd0)
                    begin
                        addr_next[15:8] = head.value;
                    end
                    else if (index_reg == 8'd1)
                    begin
                        addr_next[7:0] = head.value;
                    end
                    else if (data_pos < MAX_B)
                    begin
                        store_next[data_pos[IDX_W-1:0]] = head.value;
                    end
                    if (index_reg != 8'hFF)
                    begin
                        index_next = index_reg + 8'd1;
                    end
                end
                default:
                begin
                    sum_next = sum_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && emits)
        begin
            out_valid_next = 1'b1;
        end
        else if (rec_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg      <= 4'h0;
            count_reg     <= 8'd0;
            sum_reg       <= 8'd0;
            addr_reg      <= 16'd0;
            index_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_DATA_BYTES; i++)
            begin
                store_reg[i] <= 8'h00;
            end
        end
        else
        begin
            type_reg      <= type_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            addr_reg      <= addr_next;
            index_reg     <= index_next;
            out_valid_reg <= out_valid_next;
            store_reg     <= store_next;
        end
    end

    // Record payload: loaded only when a record completes.
    always_ff @(posedge clk)
    begin
        if (pop && emits)
        begin
            out_type_reg  <= type_reg;
            out_addr_reg  <= addr_reg;
            out_count_reg <= count_reg;
            out_ok_reg    <= ok;
            out_words_reg <= words;
            if (head.kind == TK_COUNT)
            begin
                out_count_reg <= head.value;
            end
        end
    end

    assign rec_valid    = out_valid_reg;
    assign record_type  = out_type_reg;
    assign load_address = out_addr_reg;
    assign byte_count   = out_count_reg;
    assign record_valid = out_ok_reg;
    assign data_word0   = out_words_reg[0];
    assign data_word1   = out_words_reg[1];
    assign data_word2   = out_words_reg[2];
    assign data_word3   = out_words_reg[3];

endmodule

@@ rtl/srec_record_parser_unit.sv @@
// Channel   | Dir | Beat carries
// ----------+-----+---------------------------------------------------------
// chars     | in  | char_in: one ASCII character of S-record text
// records   | out | record_type, load_address, byte_count, record_valid,
//           |     | data_word0..data_word3: one parsed record
//
// Cycles: one character is taken every cycle unless the token queue is full.
// A record is loaded into the output register once its last token is popped.
// Reset: asynchronous, active low; all control state and the data store
// clear at once, not the queue slots or payload; no clearing pass follows.
// Stalls: while records is held off, the back end keeps working on tokens
// that make no record and the four-entry token queue absorbs the front end's
// output; chars.ready drops only once that queue is full.
//
// Depends on srec_pkg, srec_if, srec_front, srec_token_queue, srec_back.
module srec_record_parser_unit
    import srec_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    srec_char_if.sink   chars,
    srec_rec_if.source  records
);

    token_t front_token;
    token_t head_token;
    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_empty;

    // Front end: frame the record, pair nibbles, classify each byte.
    srec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (chars.valid),
        .char_ready (chars.ready),
        .char_in    (chars.char_in),
        .push       (push),
        .token      (front_token),
        .queue_full (queue_full)
    );

    // Decouple the two halves so each can stall on its own.
    srec_token_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_token (front_token),
        .full     (queue_full),
        .pop      (pop),
        .rd_token (head_token),
        .empty    (queue_empty)
    );

    // Back end: accumulate checksum, address and data; hold the result.
    srec_back #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_token),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .rec_valid    (records.valid),
        .rec_ready    (records.ready),
        .record_type  (records.record_type),
        .load_address (records.load_address),
        .byte_count   (records.byte_count),
        .record_valid (records.record_valid),
        .data_word0   (records.data_word0),
        .data_word1   (records.data_word1),
        .data_word2   (records.data_word2),
        .data_word3   (records.data_word3)
    );

endmodule

@@ rtl/srec_checker.sv @@
// Port-level checks of the S-record parser, bound to the top level.
// Depends on srec_record_parser_unit's ports only.
module srec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rec_valid,
    input logic        rec_ready,
    input logic [15:0] load_address,
    input logic [7:0]  byte_count,
    input logic        record_valid,
    input logic [31:0] data_word0,
    input logic [31:0] data_word1,
    input logic [31:0] data_word2,
    input logic [31:0] data_word3
);

    // Hold a stalled beat.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_ready |=> rec_valid)
        else $error("record dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_ready |=> $stable(load_address) && $stable(byte_count)
            && $stable(record_valid) && $stable(data_word0))
        else $error("record payload changed while stalled");

    // An empty record carries nothing and never passes.
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && byte_count == 8'd0 |-> !record_valid && load_address == 16'd0
            && data_word0 == 32'd0 && data_word3 == 32'd0)
        else $error("empty record not blank");

    // With a count of one no address byte arrives.
    a_short_count: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && byte_count == 8'd1 |-> load_address == 16'd0 && data_word0 == 32'd0)
        else $error("short record holds stale address or data");

    // At most four data bytes fit in a count below eight.
    a_small_data: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && byte_count != 8'd0 && byte_count < 8'd8 |->
            data_word1 == 32'd0 && data_word2 == 32'd0 && data_word3 == 32'd0)
        else $error("data beyond record length");

endmodule

bind srec_record_parser_unit srec_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rec_valid    (records.valid),
    .rec_ready    (records.ready),
    .load_address (records.load_address),
    .byte_count   (records.byte_count),
    .record_valid (records.record_valid),
    .data_word0   (records.data_word0),
    .data_word1   (records.data_word1),
    .data_word2   (records.data_word2),
    .data_word3   (records.data_word3)
);

@@ dv/srec_record_parser_unit_tb.sv @@
// Self-checking testbench for srec_record_parser_unit: feeds S-record text
// and checks every record beat against an in-bench model or a typed row.
// Depends on srec_pkg, srec_if and the RTL of srec_record_parser_unit.
module srec_record_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srec_pkg::*;

    localparam int STORE_BYTES = MAX_DATA_BYTES_DEF;
    localparam int IDLE_PCT    = 34;
    localparam int RANDOM_CHARS = 1300;
    // Record characters inside this window are sent with no idling on either side
    localparam int STEADY_FROM = 500;
    localparam int STEADY_TO   = 800;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP   = 40;

    // One parsed record as it leaves the block
    typedef struct packed {
        logic [3:0]       rtype;
        logic [15:0]      addr;
        logic [7:0]       count;
        logic             ok;
        logic [3:0][31:0] words;
    } srec_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    srec_char_if chars_if ();
    srec_rec_if  recs_if ();

    srec_record_parser_unit #(
        .MAX_DATA_BYTES(STORE_BYTES)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .records (recs_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model: its own copy of every piece of record state
    // ------------------------------------------------------------------
    phase_t      ph = PH_IDLE;
    logic [3:0]  hi_nib = '0;
    logic        nib_held = 1'b0;
    logic [7:0]  bytes_left = '0;
    logic [7:0]  body_idx = '0;
    logic [7:0]  run_sum = '0;
    logic [7:0]  rec_count = '0;
    logic [3:0]  rec_type = '0;
    logic [15:0] rec_addr = '0;
    logic [7:0]  data_bytes [STORE_BYTES];

    srec_result_t pending_records [$];   // expectations, oldest first
    srec_result_t typed_records [$];     // hand-written expectations of table rows

    int mismatch_count  = 0;
    int chars_taken     = 0;
    int records_checked = 0;
    int good_sums       = 0;
    int zero_counts     = 0;
    int overflow_recs   = 0;
    int body_chars      = 0;
    bit steady          = 1'b0;

    // Hex digit value; every other character counts as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= "0" && c <= "9")
        begin
            v = c - "0";
        end
        else if (c >= "A" && c <= "F")
        begin
            v = c - "A" + 8'd10;
        end
        else if (c >= "a" && c <= "f")
        begin
            v = c - "a" + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return "0" + 8'(n);
        end
        return (lower ? "a" : "A") + 8'(n) - 8'd10;
    endfunction

    function automatic srec_result_t make_result(input logic [3:0] rtype,
                                                 input logic [15:0] addr,
                                                 input logic [7:0] count,
                                                 input logic ok);
        srec_result_t r;
        r       = '0;
        r.rtype = rtype;
        r.addr  = addr;
        r.count = count;
        r.ok    = ok;
        return r;
    endfunction

    // Close the current record and queue what the block must send
    function automatic void finish_record(input logic ok);
        srec_result_t r;
        int idx;
        r = make_result(rec_type, rec_addr, rec_count, ok);
        for (int k = 0; k < 4; k++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                idx = k * 4 + b;
                r.words[k] = {r.words[k][23:0], (idx < STORE_BYTES) ? data_bytes[idx] : 8'h00};
            end
        end
        // A table row with a typed expectation takes the place of the model's
        if (typed_records.size() > 0)
        begin
            r = typed_records.pop_front();
        end
        pending_records.push_back(r);
        if (ok)
        begin
            good_sums++;
        end
        if (rec_count == 8'd0)
        begin
            zero_counts++;
        end
        if (int'(rec_count) > STORE_BYTES + 3)
        begin
            overflow_recs++;
        end
        ph       = PH_IDLE;
        nib_held = 1'b0;
    endfunction

    // Advance the model by one accepted character
    function automatic void absorb_char(input logic [7:0] c);
        logic [7:0] b;
        if (ph == PH_IDLE)
        begin
            if (c == CHAR_S)
            begin
                ph         = PH_TYPE;
                hi_nib     = '0;
                nib_held   = 1'b0;
                bytes_left = '0;
                body_idx   = '0;
                run_sum    = '0;
                rec_count  = '0;
                rec_type   = '0;
                rec_addr   = '0;
                foreach (data_bytes[i])
                begin
                    data_bytes[i] = 8'h00;
                end
            end
        end
        else if (ph == PH_TYPE)
        begin
            rec_type = hex_value(c);
            ph       = PH_COUNT;
            nib_held = 1'b0;
        end
        else if (!nib_held)
        begin
            hi_nib   = hex_value(c);
            nib_held = 1'b1;
        end
        else
        begin
            nib_held = 1'b0;
            b = {hi_nib, hex_value(c)};
            if (ph == PH_COUNT)
            begin
                rec_count  = b;
                run_sum    = b;
                bytes_left = b;
                body_idx   = '0;
                if (b == 8'd0)
                begin
                    finish_record(1'b0);
                end
                else
                begin
                    ph = PH_BODY;
                end
            end
            else if (bytes_left <= 8'd1)
            begin
                // checksum byte: one's complement of the running sum
                finish_record(~run_sum == b);
            end
            else
            begin
                run_sum = run_sum + b;
                if (body_idx == 8'd0)
                begin
                    rec_addr[15:8] = b;
                end
                else if (body_idx == 8'd1)
                begin
                    rec_addr[7:0] = b;
                end
                else if (int'(body_idx) - 2 < STORE_BYTES)
                begin
                    data_bytes[body_idx - 8'd2] = b;
                end
                if (body_idx < 8'd255)
                begin
                    body_idx++;
                end
                bytes_left--;
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitors: sample both channels at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            chars_taken++;
            absorb_char(chars_if.char_in);
        end
    end

    always @(posedge clk)
    begin
        srec_result_t got;
        srec_result_t want;
        if (rst_n && recs_if.valid && recs_if.ready)
        begin
            got.rtype    = recs_if.record_type;
            got.addr     = recs_if.load_address;
            got.count    = recs_if.byte_count;
            got.ok       = recs_if.record_valid;
            got.words[0] = recs_if.data_word0;
            got.words[1] = recs_if.data_word1;
            got.words[2] = recs_if.data_word2;
            got.words[3] = recs_if.data_word3;
            if (pending_records.size() == 0)
            begin
                report_mismatch($sformatf("record beat with none expected (type %0h addr %04h)",
                                          got.rtype, got.addr));
            end
            else
            begin
                want = pending_records.pop_front();
                records_checked++;
                if (got.rtype !== want.rtype)
                begin
                    report_mismatch($sformatf("record_type %0h, expected %0h",
                                              got.rtype, want.rtype));
                end
                if (got.addr !== want.addr)
                begin
                    report_mismatch($sformatf("load_address %04h, expected %04h",
                                              got.addr, want.addr));
                end
                if (got.count !== want.count)
                begin
                    report_mismatch($sformatf("byte_count %02h, expected %02h",
                                              got.count, want.count));
                end
                if (got.ok !== want.ok)
                begin
                    report_mismatch($sformatf("record_valid %b, expected %b",
                                              got.ok, want.ok));
                end
                for (int k = 0; k < 4; k++)
                begin
                    if (got.words[k] !== want.words[k])
                    begin
                        report_mismatch($sformatf("data_word%0d %08h, expected %08h",
                                                  k, got.words[k], want.words[k]));
                    end
                end
            end
        end
    end

    // Record sink: drop ready about a third of the time, hold it during the steady window
    initial
    begin
        recs_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            recs_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Character source
    // ------------------------------------------------------------------

    // Offer one character; returns on the falling edge after its beat
    task automatic send_char(input logic [7:0] c);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            chars_if.valid   <= 1'b0;
            chars_if.char_in <= 8'($urandom);
            @(negedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.char_in <= c;
        @(posedge clk);
        while (!chars_if.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Mostly a hex digit in either case, now and then any byte at all
    task automatic send_nibble(input logic [3:0] n);
        body_chars++;
        steady = (body_chars >= STEADY_FROM) && (body_chars < STEADY_TO);
        if ($urandom_range(99) < 2)
        begin
            send_char(8'($urandom));
        end
        else
        begin
            send_char(hex_char(n, $urandom_range(99) < 30));
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_nibble(b[7:4]);
        send_nibble(b[3:0]);
    endtask

    // One record with random content, a little noise ahead of it, and
    // occasionally a bad checksum or a truncated body
    task automatic send_random_record();
        logic [7:0] noise;
        logic [7:0] cnt;
        logic [7:0] sum;
        logic [7:0] b;
        int roll;
        bit cut;
        int cut_at;
        repeat ($urandom_range(0, 2))
        begin
            noise = 8'($urandom);
            if (noise == CHAR_S)
            begin
                noise = 8'h0a;
            end
            send_char(noise);
        end
        send_char(CHAR_S);
        if ($urandom_range(99) < 85)
        begin
            send_char(hex_char(4'($urandom), $urandom_range(1)));
        end
        else
        begin
            send_char(8'($urandom));
        end
        roll = $urandom_range(99);
        if (roll < 5)
        begin
            cnt = 8'd0;
        end
        else if (roll < 13)
        begin
            cnt = 8'($urandom_range(1, 2));
        end
        else if (roll < 80)
        begin
            cnt = 8'($urandom_range(3, 12));
        end
        else if (roll < 97)
        begin
            cnt = 8'($urandom_range(13, 24));
        end
        else
        begin
            cnt = 8'($urandom_range(25, 255));
        end
        send_byte(cnt);
        if (cnt == 8'd0)
        begin
            return;
        end
        sum    = cnt;
        cut    = ($urandom_range(99) < 3);
        cut_at = $urandom_range(0, int'(cnt));
        for (int i = 0; i < int'(cnt) - 1; i++)
        begin
            if (cut && i == cut_at)
            begin
                return;
            end
            b = 8'($urandom);
            // push the address bytes to their extremes now and then
            if (i < 2 && $urandom_range(99) < 15)
            begin
                b = $urandom_range(1) ? 8'hff : 8'h00;
            end
            sum = sum + b;
            send_byte(b);
        end
        send_byte(($urandom_range(99) < 75) ? ~sum : 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Directed table: record text, and an expectation where one is obvious
    // ------------------------------------------------------------------
    string        row_text [$];
    bit           row_typed [$];
    srec_result_t row_want [$];

    task automatic add_row(input string text, input bit typed, input srec_result_t want);
        row_text.push_back(text);
        row_typed.push_back(typed);
        row_want.push_back(want);
    endtask

    initial
    begin
        string line;
        string long_line;
        chars_if.valid   = 1'b0;
        chars_if.char_in = 8'h00;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero count ends the record at once, invalid
        add_row("S100", 1'b1, make_result(4'h1, 16'h0000, 8'h03 - 8'h03, 1'b0));
        // idle noise ahead, lowest address, good checksum
        add_row("zS1030000FC", 1'b1, make_result(4'h1, 16'h0000, 8'h03, 1'b1));
        // highest address
        add_row("S103FFFFFE", 1'b1, make_result(4'h1, 16'hffff, 8'h03, 1'b1));
        // checksum off by one
        add_row("S1030000FB", 1'b1, make_result(4'h1, 16'h0000, 8'h03, 1'b0));
        // short count: checksum arrives before the address, other record type
        add_row("S901FE", 1'b1, make_result(4'h9, 16'h0000, 8'h01, 1'b1));
        // non-hex type and checksum characters decode as zero
        add_row("Sg02AB??", 1'b0, '0);
        // more data than the store holds, lower-case digits
        long_line = "S1140000";
        repeat (17)
        begin
            long_line = {long_line, "ff"};
        end
        long_line = {long_line, "fc"};
        add_row(long_line, 1'b0, '0);

        for (int r = 0; r < row_text.size(); r++)
        begin
            if (row_typed[r])
            begin
                typed_records.push_back(row_want[r]);
            end
            line = row_text[r];
            for (int i = 0; i < line.len(); i++)
            begin
                send_char(line[i]);
            end
        end

        // random records until enough record text has gone in
        while (body_chars < RANDOM_CHARS)
        begin
            send_random_record();
        end
        steady = 1'b0;
        chars_if.valid <= 1'b0;

        // drain, then give a late or stray beat time to show up
        while (pending_records.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_records.size() != 0)
        begin
            report_mismatch($sformatf("%0d records never arrived", pending_records.size()));
        end

        $display("covered %0d characters and %0d records: %0d good checksums,",
                 chars_taken, records_checked, good_sums);
        $display("%0d zero-count records, %0d with data past the store, %0d mismatches",
                 zero_counts, overflow_recs, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("timeout: %0d records still outstanding", pending_records.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
